FILE: design/mhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mhd_pkg
// Types, constants and the arctangent table for the magnetometer heading block.
// ----------------------------------------------------------------------------
package mhd_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int MAG_W  = 16;
    localparam int CTR_W  = 18;              // doubled, centred sample
    localparam int RNG_W  = 17;              // axis range, unsigned
    localparam int PROD_W = CTR_W + RNG_W;   // centred sample times range
    localparam int ROT_W  = PROD_W + 24 + 3; // CORDIC vector, with headroom

    localparam logic signed [MAG_W-1:0] LOW_RESET  = 16'sh7FFF;
    localparam logic signed [MAG_W-1:0] HIGH_RESET = 16'sh8000;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic                    op;
        logic signed [MAG_W-1:0] mag_x;
        logic signed [MAG_W-1:0] mag_y;
    } in_item_t;

    typedef struct packed {
        logic [15:0] heading;
        logic        not_calibrated;
    } out_item_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_raw(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // table entry rounded to nearest in ANGLE_BITS units
    function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [4:0] i);
        logic [32:0] s;
        s = {1'b0, atan_raw(i)} + (33'd1 << (31 - ANGLE_BITS));
        return s[32-ANGLE_BITS +: ANGLE_BITS];
    endfunction

endpackage
`default_nettype wire

FILE: design/magnetometer_heading_with_autocal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_heading_with_autocal
// Heading from raw X/Y magnetometer samples with min/max hard-iron calibration.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one item: op, mag_x, mag_y. op restart clears the
//   calibration extremes and returns heading 0 with not_calibrated set.
//   out_valid/out_ready carry one result item per input item, in order.
//   cfg_valid/cfg_ready write the declination register; cfg_ready is always
//   high. Write it only while the block is idle.
// Sequencing:
//   A sample with both ranges non-zero goes from acceptance through S_PREP,
//   the bit-serial range multiply in S_MUL, S_LOAD, the CORDIC_STEPS steps
//   in S_ROT and S_DONE to out_valid. Restart, zero range and centred
//   samples go from S_PREP straight to S_DONE. One item is in work at a time;
//   the next is taken once the previous result has moved to the output
//   register.
// Reset: extremes go to +32767/-32768, declination to 0, no item in work.
// Stall: a finished result waits in the output register while out_ready is
//   low; the next item is accepted and runs up to its own result meanwhile.
// ----------------------------------------------------------------------------
module magnetometer_heading_with_autocal (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mhd_pkg::in_item_t   in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mhd_pkg::out_item_t       out_item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic signed [15:0]  cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_ROT  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam int AB   = mhd_pkg::ANGLE_BITS;
    localparam int CW   = mhd_pkg::CTR_W;
    localparam int RW   = mhd_pkg::RNG_W;
    localparam int PW   = mhd_pkg::PROD_W;
    localparam int VW   = mhd_pkg::ROT_W;
    localparam int CONV_W = AB + 17;
    localparam logic [4:0] MUL_LAST = 5'(RW - 1);
    localparam logic [4:0] ROT_LAST = 5'(mhd_pkg::CORDIC_STEPS - 1);

    logic [2:0]               state_reg, state_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic signed [15:0]       decl_reg;
    logic signed [15:0]       xl_reg, xl_next, xh_reg, xh_next;
    logic signed [15:0]       yl_reg, yl_next, yh_reg, yh_next;
    logic signed [15:0]       mx_reg, my_reg;
    logic                     op_reg;
    logic signed [PW-1:0]     mcx_reg, mcx_next, mcy_reg, mcy_next;
    logic [RW-1:0]            mpx_reg, mpx_next, mpy_reg, mpy_next;
    logic signed [PW-1:0]     accx_reg, accx_next, accy_reg, accy_next;
    logic signed [VW-1:0]     vx_reg, vx_next, vy_reg, vy_next;
    logic [AB-1:0]            ang_reg, ang_next;
    logic [15:0]              rh_reg, rh_next;
    logic                     rf_reg, rf_next;
    logic                     out_valid_reg, out_valid_next;
    mhd_pkg::out_item_t       out_item_reg, out_item_next;

    logic                     accept;
    logic signed [RW-1:0]     rx, ry;
    logic signed [CW-1:0]     cx, cy;
    logic                     zero_range;
    logic signed [VW-1:0]     ix, iy, dx, dy;
    logic [AB-1:0]            ang_step;
    logic [CONV_W-1:0]        conv;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        rx = RW'(xh_reg) - RW'(xl_reg);
        ry = RW'(yh_reg) - RW'(yl_reg);
        cx = (CW'(mx_reg) <<< 1) - (CW'(xh_reg) + CW'(xl_reg));
        cy = (CW'(my_reg) <<< 1) - (CW'(yh_reg) + CW'(yl_reg));
        zero_range = (xl_reg == xh_reg) || (yl_reg == yh_reg);
        ix = {{(VW-PW-24){accx_reg[PW-1]}}, accx_reg, 24'd0};
        iy = {{(VW-PW-24){accy_reg[PW-1]}}, accy_reg, 24'd0};
        dx = vy_reg >>> cnt_reg;
        dy = vx_reg >>> cnt_reg;
        ang_step = mhd_pkg::atan_step(cnt_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        xl_next        = xl_reg;
        xh_next        = xh_reg;
        yl_next        = yl_reg;
        yh_next        = yh_reg;
        mcx_next       = mcx_reg;
        mcy_next       = mcy_reg;
        mpx_next       = mpx_reg;
        mpy_next       = mpy_reg;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        ang_next       = ang_reg;
        rh_next        = rh_reg;
        rf_next        = rf_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        conv           = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_item.op == mhd_pkg::OP_RESTART)
                    begin
                        xl_next = mhd_pkg::LOW_RESET;
                        xh_next = mhd_pkg::HIGH_RESET;
                        yl_next = mhd_pkg::LOW_RESET;
                        yh_next = mhd_pkg::HIGH_RESET;
                    end
                    else
                    begin
                        // low and high each move on their own
                        if (in_item.mag_x < xl_reg) xl_next = in_item.mag_x;
                        if (in_item.mag_x > xh_reg) xh_next = in_item.mag_x;
                        if (in_item.mag_y < yl_reg) yl_next = in_item.mag_y;
                        if (in_item.mag_y > yh_reg) yh_next = in_item.mag_y;
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (op_reg == mhd_pkg::OP_RESTART || zero_range)
                begin
                    rh_next    = 16'd0;
                    rf_next    = 1'b1;
                    state_next = S_DONE;
                end
                else if (cx == '0 && cy == '0)
                begin
                    rh_next    = decl_reg;
                    rf_next    = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    // X = cx*ry, Y = cy*rx
                    mcx_next   = PW'(cx);
                    mcy_next   = PW'(cy);
                    mpx_next   = ry;
                    mpy_next   = rx;
                    accx_next  = '0;
                    accy_next  = '0;
                    cnt_next   = 5'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mpx_reg[0]) accx_next = accx_reg + mcx_reg;
                if (mpy_reg[0]) accy_next = accy_reg + mcy_reg;
                mcx_next = mcx_reg <<< 1;
                mcy_next = mcy_reg <<< 1;
                mpx_next = mpx_reg >> 1;
                mpy_next = mpy_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == MUL_LAST)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                // left half plane: rotate by half a turn first
                if (ix < 0)
                begin
                    vx_next  = -ix;
                    vy_next  = -iy;
                    ang_next = AB'(1) << (AB - 1);
                end
                else
                begin
                    vx_next  = ix;
                    vy_next  = iy;
                    ang_next = '0;
                end
                cnt_next   = 5'd0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (vy_reg >= 0)
                begin
                    vx_next  = vx_reg + dx;
                    vy_next  = vy_reg - dy;
                    ang_next = ang_reg + ang_step;
                end
                else
                begin
                    vx_next  = vx_reg - dx;
                    vy_next  = vy_reg + dy;
                    ang_next = ang_reg - ang_step;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == ROT_LAST)
                begin
                    conv = ({1'b0, ang_next, 16'd0} + (CONV_W'(1) << (AB - 1))) >> AB;
                    rh_next    = conv[15:0] + decl_reg;
                    rf_next    = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.heading        = rh_reg;
                    out_item_next.not_calibrated = rf_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 5'd0;
            decl_reg      <= 16'sd0;
            xl_reg        <= mhd_pkg::LOW_RESET;
            xh_reg        <= mhd_pkg::HIGH_RESET;
            yl_reg        <= mhd_pkg::LOW_RESET;
            yh_reg        <= mhd_pkg::HIGH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            xl_reg        <= xl_next;
            xh_reg        <= xh_next;
            yl_reg        <= yl_next;
            yh_reg        <= yh_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                decl_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= in_item.op;
            mx_reg <= in_item.mag_x;
            my_reg <= in_item.mag_y;
        end
        mcx_reg      <= mcx_next;
        mcy_reg      <= mcy_next;
        mpx_reg      <= mpx_next;
        mpy_reg      <= mpy_next;
        accx_reg     <= accx_next;
        accy_reg     <= accy_next;
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        ang_reg      <= ang_next;
        rh_reg       <= rh_next;
        rf_reg       <= rf_next;
        out_item_reg <= out_item_next;
    end

`ifndef SYNTHESIS
    a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> (cnt_reg <= ROT_LAST))
        else $error("CORDIC step count out of range");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (cnt_reg <= MUL_LAST))
        else $error("multiply bit count out of range");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.not_calibrated) |-> (out_item_reg.heading == 16'd0))
        else $error("uncalibrated item with non-zero heading");

    a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP && op_reg == mhd_pkg::OP_SAMPLE)
            |-> (xl_reg <= xh_reg && yl_reg <= yh_reg))
        else $error("extremes crossed after a sample");
`endif

endmodule
`default_nettype wire
